>>> rtl/core/brsci_pkg.sv
`default_nettype none

package brsci_pkg;

   // fixed widths of the request and response fields
   localparam int FIELD_W   = 13;
   localparam int WIDX_W    = 8;
   localparam int DATA_W    = 32;
   // widest bit offset inside a word (words of up to 64 bits)
   localparam int OFS_MAX_W = 6;

   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_INVERT = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_REPLY
   } bst_type;

   // classified command handed from the front end to the back end
   typedef struct packed {
      op_type                 op;
      logic                   act;         // memory is touched (or read word exists)
      logic                   err;         // reversed range
      logic [FIELD_W-1:0]     first_word;  // read word for a read
      logic [FIELD_W-1:0]     last_word;
      logic [OFS_MAX_W-1:0]   first_ofs;
      logic [OFS_MAX_W-1:0]   last_ofs;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              range_error;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/bitmap_range_set_clear_invert.sv
// bitmap range set / clear / invert with word read-back
//
// request channel: a transfer happens on a clock edge with push high and full low;
// func selects set, clear or invert of the inclusive bit range first_bit..last_bit,
// or a read of the word at word_index
// response channel: the oldest response sits on the rsp_ ports while empty is low
// and transfers on an edge with pop high; exactly one response per request, in order
// path: the request is registered in the classify stage and passes the command queue;
// the back end then reads and writes each covered word of the single-port bitmap
// memory in turn, a read fetches at most one word and a no-op range touches none;
// the read-modify-write walk over the covered words sets the throughput
// reset: the bitmap memory is zeroed by a pass of one word per cycle,
// with full held high until it ends
// stall: a waiting response sits in a small output queue; the back end keeps
// working until that queue fills, then the command queue fills and full rises
`default_nettype none

module bitmap_range_set_clear_invert #(
   parameter int MAP_BITS    = 8192,
   parameter int WORD_BITS   = 32,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [1:0]                    req_func,
   input  wire logic [brsci_pkg::FIELD_W-1:0] req_first_bit,
   input  wire logic [brsci_pkg::FIELD_W-1:0] req_last_bit,
   input  wire logic [brsci_pkg::WIDX_W-1:0]  req_word_index,
   // response channel
   output logic                               empty,
   input  wire logic                          pop,
   output logic [brsci_pkg::DATA_W-1:0]       rsp_read_data,
   output logic                               rsp_range_error
);

   import brsci_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cmd_type          front_cmd;
   logic             front_push;
   logic             cmdq_full;
   logic [CMD_W-1:0] cmdq_data;
   logic             cmdq_empty;
   logic             cmdq_pop;
   logic             clearing;
   rsp_type          back_rsp;
   logic             back_push;
   logic             rspq_full;
   logic [RSP_W-1:0] rspq_data;
   rsp_type          out_rsp;

   // front end: register and classify the request, split bit indexes into word/offset
   brsci_front #(
      .MAP_BITS  (MAP_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .func       (req_func),
      .first_bit  (req_first_bit),
      .last_bit   (req_last_bit),
      .word_index (req_word_index),
      .clearing   (clearing),
      .cmd_push   (front_push),
      .cmd        (front_cmd),
      .cmd_full   (cmdq_full)
   );

   // command queue between front and back
   brsci_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (cmdq_full),
      .pop       (cmdq_pop),
      .pop_data  (cmdq_data),
      .empty     (cmdq_empty)
   );

   // back end: owns the bitmap memory and walks the covered words
   brsci_back #(
      .MAP_BITS  (MAP_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmdq_empty),
      .cmd       (cmd_type'(cmdq_data)),
      .cmd_pop   (cmdq_pop),
      .clearing  (clearing),
      .rsp_push  (back_push),
      .rsp       (back_rsp),
      .rsp_full  (rspq_full)
   );

   // response queue toward the receiver
   brsci_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rspq_full),
      .pop       (pop),
      .pop_data  (rspq_data),
      .empty     (empty)
   );

   assign out_rsp         = rsp_type'(rspq_data);
   assign rsp_read_data   = out_rsp.read_data;
   assign rsp_range_error = out_rsp.range_error;

endmodule

`default_nettype wire

>>> rtl/core/brsci_fifo.sv
`default_nettype none

module brsci_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = data_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/brsci_front.sv
`default_nettype none

module brsci_front #(
   parameter int MAP_BITS  = 8192,
   parameter int WORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [1:0]                    func,
   input  wire logic [brsci_pkg::FIELD_W-1:0] first_bit,
   input  wire logic [brsci_pkg::FIELD_W-1:0] last_bit,
   input  wire logic [brsci_pkg::WIDX_W-1:0]  word_index,
   input  wire logic                          clearing,
   output logic                               cmd_push,
   output brsci_pkg::cmd_type                 cmd,
   input  wire logic                          cmd_full
);

   import brsci_pkg::*;

   localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int OFS_W     = $clog2(WORD_BITS);
   // reciprocal of the word size, precise enough that the quotient is low by at most one
   localparam int RSHIFT    = FIELD_W + OFS_W + 1;
   localparam int PROD_W    = FIELD_W + RSHIFT;
   localparam logic [PROD_W-1:0] RECIP = PROD_W'((64'd1 << RSHIFT) / WORD_BITS);
   localparam logic [FIELD_W-1:0] WORD_SIZE = FIELD_W'(WORD_BITS);
   localparam logic [FIELD_W-1:0] MAP_LAST  = FIELD_W'(MAP_BITS - 1);

   op_type             op;
   logic               is_read;
   logic               rev;
   logic               in_map;
   logic               accept;
   logic [FIELD_W-1:0] last_clip;
   logic [PROD_W-1:0]  prod_first, prod_last;

   logic               valid_ff, valid_in;
   op_type             op_ff;
   logic               act_ff;
   logic               err_ff;
   logic [FIELD_W-1:0] first_ff, last_ff;
   logic [FIELD_W-1:0] qf_ff, ql_ff;
   logic [WIDX_W-1:0]  widx_ff;

   logic [FIELD_W-1:0]   qf_fix, ql_fix;
   logic [OFS_MAX_W-1:0] rf_fix, rl_fix;

   // remainder correction after the reciprocal estimate
   function automatic logic [FIELD_W+OFS_MAX_W-1:0] fix_div(
      input logic [FIELD_W-1:0] x,
      input logic [FIELD_W-1:0] q
   );
      logic [FIELD_W-1:0] qw;
      logic [FIELD_W-1:0] r_raw;
      logic [OFS_W:0]     rem;
      logic [OFS_W:0]     r;
      logic [FIELD_W-1:0] q_out;
      qw    = q * WORD_SIZE;
      r_raw = x - qw;
      rem   = r_raw[OFS_W:0];
      if (rem >= (OFS_W+1)'(WORD_BITS)) begin
         r     = rem - (OFS_W+1)'(WORD_BITS);
         q_out = q + 1'b1;
      end else begin
         r     = rem;
         q_out = q;
      end
      return {q_out, OFS_MAX_W'(r[OFS_W-1:0])};
   endfunction

   assign op      = op_type'(func);
   assign is_read = (op == OP_READ);
   assign rev     = !is_read && (first_bit > last_bit);
   assign in_map  = (32'(first_bit) < 32'(MAP_BITS));
   assign last_clip = (32'(last_bit) > 32'(MAP_BITS - 1)) ? MAP_LAST : last_bit;

   assign prod_first = PROD_W'(first_bit) * RECIP;
   assign prod_last  = PROD_W'(last_clip) * RECIP;

   assign cmd_push = valid_ff && !cmd_full;
   assign full     = clearing || (valid_ff && cmd_full);
   assign accept   = push && !full;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (cmd_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op;
         err_ff   <= rev;
         act_ff   <= is_read ? (32'(word_index) < 32'(NUM_WORDS)) : (!rev && in_map);
         first_ff <= first_bit;
         last_ff  <= last_clip;
         qf_ff    <= prod_first[RSHIFT +: FIELD_W];
         ql_ff    <= prod_last[RSHIFT +: FIELD_W];
         widx_ff  <= word_index;
      end
   end

   assign {qf_fix, rf_fix} = fix_div(first_ff, qf_ff);
   assign {ql_fix, rl_fix} = fix_div(last_ff, ql_ff);

   always_comb begin
      cmd.op         = op_ff;
      cmd.act        = act_ff;
      cmd.err        = err_ff;
      cmd.first_word = (op_ff == OP_READ) ? FIELD_W'(widx_ff) : qf_fix;
      cmd.last_word  = ql_fix;
      cmd.first_ofs  = rf_fix;
      cmd.last_ofs   = rl_fix;
   end

endmodule

`default_nettype wire

>>> rtl/core/brsci_back.sv
`default_nettype none

module brsci_back #(
   parameter int MAP_BITS  = 8192,
   parameter int WORD_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_empty,
   input  wire brsci_pkg::cmd_type cmd,
   output logic                    cmd_pop,
   output logic                    clearing,
   output logic                    rsp_push,
   output brsci_pkg::rsp_type      rsp,
   input  wire logic               rsp_full
);

   import brsci_pkg::*;

   localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int OFS_W     = $clog2(WORD_BITS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);
   localparam logic [OFS_W-1:0] TOP_OFS  = OFS_W'(WORD_BITS - 1);

   logic [WORD_BITS-1:0] words_mem [NUM_WORDS];

   bst_type              state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [WORD_BITS-1:0] rd_data_ff;

   logic                 mem_rd;
   logic                 mem_wr;
   logic [IDX_W-1:0]     mem_addr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 at_first, at_last;
   logic [OFS_W-1:0]     lo, hi;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] modified;

   assign at_first = (cur_ff == IDX_W'(cmd_ff.first_word));
   assign at_last  = (cur_ff == IDX_W'(cmd_ff.last_word));
   assign lo       = at_first ? cmd_ff.first_ofs[OFS_W-1:0] : '0;
   assign hi       = at_last ? cmd_ff.last_ofs[OFS_W-1:0] : TOP_OFS;
   assign mask     = ({WORD_BITS{1'b1}} >> (TOP_OFS - hi)) & ({WORD_BITS{1'b1}} << lo);

   always_comb begin
      case (cmd_ff.op)
         OP_SET:    modified = rd_data_ff | mask;
         OP_CLEAR:  modified = rd_data_ff & ~mask;
         OP_INVERT: modified = rd_data_ff ^ mask;
         default:   modified = rd_data_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!cmd_empty) state_in = cmd.act ? ST_READ : ST_REPLY;
         end
         ST_READ: begin
            state_in = (cmd_ff.op == OP_READ) ? ST_REPLY : ST_WRITE;
         end
         ST_WRITE: begin
            state_in = at_last ? ST_REPLY : ST_READ;
         end
         ST_REPLY: begin
            if (!rsp_full) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      cmd_pop   = 1'b0;
      clearing  = 1'b0;
      mem_rd    = 1'b0;
      mem_wr    = 1'b0;
      mem_addr  = cur_ff;
      mem_wdata = modified;
      rsp_push  = 1'b0;
      cmd_in    = cmd_ff;
      cur_in    = cur_ff;
      clr_in    = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clearing  = 1'b1;
            mem_wr    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            cmd_pop = !cmd_empty;
            if (!cmd_empty) begin
               cmd_in = cmd;
               cur_in = IDX_W'(cmd.first_word);
            end
         end
         ST_READ: begin
            mem_rd = 1'b1;
         end
         ST_WRITE: begin
            mem_wr = 1'b1;
            if (!at_last) cur_in = cur_ff + 1'b1;
         end
         ST_REPLY: begin
            rsp_push = 1'b1;
         end
         default: begin
            clearing = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp.range_error = cmd_ff.err;
      rsp.read_data   = (cmd_ff.op == OP_READ && cmd_ff.act) ? DATA_W'(rd_data_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         words_mem[mem_addr] <= mem_wdata;
      end
      if (mem_rd) begin
         rd_data_ff <= words_mem[mem_addr];
      end
   end

endmodule

`default_nettype wire
